// ===== hdl/tgrr_pkg.sv =====
// Package for the two-group round-robin picker.
// Holds group size constants, widths and the pick struct; no dependencies.
package tgrr_pkg;

    localparam int SLOTS_PER_GROUP = 8;
    localparam int MASK_W          = 8;
    localparam int GRANT_SLOT_W    = 3;
    localparam int SLOT_W          = $clog2(SLOTS_PER_GROUP);
    // Search vector covers both the group and the mask width
    localparam int WIDE_W = (SLOTS_PER_GROUP > MASK_W) ? SLOTS_PER_GROUP : MASK_W;
    localparam int WIDE_IDX_W = $clog2(WIDE_W);

    localparam logic GROUP_A = 1'b0;
    localparam logic GROUP_B = 1'b1;

    typedef struct packed {
        logic              granted;
        logic              group;
        logic [SLOT_W-1:0] slot;
    } pick_t;

endpackage

// ===== hdl/tgrr_group_search.sv =====
// Rotating priority search inside one group.
// Depends on tgrr_pkg.
module tgrr_group_search
    import tgrr_pkg::*;
(
    input  logic [MASK_W-1:0] mask,
    input  logic [SLOT_W-1:0] last_slot,
    output logic              hit,
    output logic [SLOT_W-1:0] slot
);

    logic [WIDE_W-1:0] wide_mask;

    assign wide_mask = WIDE_W'(mask);

    // Walk from farthest to nearest so the nearest hit after last_slot wins.
    always_comb begin
        logic [SLOT_W:0] sum;
        logic [SLOT_W:0] pos;
        hit  = 1'b0;
        slot = '0;
        for (int k = SLOTS_PER_GROUP; k >= 1; k--) begin
            sum = {1'b0, last_slot} + (SLOT_W+1)'(k);
            if (sum >= (SLOT_W+1)'(SLOTS_PER_GROUP)) begin
                pos = sum - (SLOT_W+1)'(SLOTS_PER_GROUP);
            end else begin
                pos = sum;
            end
            if (wide_mask[WIDE_IDX_W'(pos)]) begin
                hit  = 1'b1;
                slot = pos[SLOT_W-1:0];
            end
        end
    end

endmodule

// ===== hdl/tgrr_picker.sv =====
// Group order, last-served state and the final pick.
// Depends on tgrr_pkg and tgrr_group_search.
module tgrr_picker
    import tgrr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [MASK_W-1:0] mask_a,
    input  logic [MASK_W-1:0] mask_b,
    input  logic              update,
    output pick_t             pick
);

    logic [SLOT_W-1:0] last_slot_a_reg, last_slot_a_next;
    logic [SLOT_W-1:0] last_slot_b_reg, last_slot_b_next;
    logic              last_group_reg, last_group_next;

    logic              hit_a, hit_b;
    logic [SLOT_W-1:0] slot_a, slot_b;

    tgrr_group_search u_search_a (
        .mask      (mask_a),
        .last_slot (last_slot_a_reg),
        .hit       (hit_a),
        .slot      (slot_a)
    );

    tgrr_group_search u_search_b (
        .mask      (mask_b),
        .last_slot (last_slot_b_reg),
        .hit       (hit_b),
        .slot      (slot_b)
    );

    // Group not served last goes first
    always_comb begin
        pick = '0;
        if (last_group_reg == GROUP_B) begin
            if (hit_a) begin
                pick = '{granted: 1'b1, group: GROUP_A, slot: slot_a};
            end else if (hit_b) begin
                pick = '{granted: 1'b1, group: GROUP_B, slot: slot_b};
            end
        end else begin
            if (hit_b) begin
                pick = '{granted: 1'b1, group: GROUP_B, slot: slot_b};
            end else if (hit_a) begin
                pick = '{granted: 1'b1, group: GROUP_A, slot: slot_a};
            end
        end
    end

    always_comb begin
        last_slot_a_next = last_slot_a_reg;
        last_slot_b_next = last_slot_b_reg;
        last_group_next  = last_group_reg;
        if (update && pick.granted) begin
            last_group_next = pick.group;
            if (pick.group == GROUP_A) begin
                last_slot_a_next = pick.slot;
            end else begin
                last_slot_b_next = pick.slot;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_slot_a_reg <= SLOT_W'(SLOTS_PER_GROUP - 1);
            last_slot_b_reg <= SLOT_W'(SLOTS_PER_GROUP - 1);
            last_group_reg  <= GROUP_B;
        end else begin
            last_slot_a_reg <= last_slot_a_next;
            last_slot_b_reg <= last_slot_b_next;
            last_group_reg  <= last_group_next;
        end
    end

`ifndef SYNTH
    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !update |=> $stable(last_group_reg) && $stable(last_slot_a_reg)
                    && $stable(last_slot_b_reg))
        else $error("last-served state changed without a pick");

    a_group_recorded: assert property (@(posedge aclk) disable iff (!aresetn)
        update && pick.granted |=> last_group_reg == $past(pick.group))
        else $error("served group not recorded");
`endif

endmodule

// ===== hdl/two_group_round_robin_picker_top.sv =====
// Top level of the two-group round-robin picker.
// Depends on tgrr_pkg and tgrr_picker.
// Usage:
//   s_ channel: one word per scheduler tick, two 8-bit request masks
//   (group A and group B), one bit per slot.
//   m_ channel: one result word per tick: m_granted, m_grant_group
//   (0 = A, 1 = B) and m_grant_slot; all zero on an idle tick.
//   An accepted word goes to the input register, then to the result register
//   that drives m_. Throughput: one word per cycle while m_ready is high;
//   the rotating search over the two masks and the group choice sit between
//   the input and result registers, and the last-served state updates on
//   the same edge as the result register, so the next word sees it at once.
//   Stall: when m_ready is low the result holds and one more word can wait
//   in the input register; s_ready drops only when both are full.
//   Reset (aresetn low, synchronous): both registers empty, every group's
//   last-served slot set to the top slot so searches start at slot zero,
//   and group B marked as served last so group A goes first.
module two_group_round_robin_picker_top
    import tgrr_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [MASK_W-1:0]       s_requests_group_a,
    input  logic [MASK_W-1:0]       s_requests_group_b,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_granted,
    output logic                    m_grant_group,
    output logic [GRANT_SLOT_W-1:0] m_grant_slot
);

    logic              in_valid_reg, in_valid_next;
    logic [MASK_W-1:0] mask_a_reg, mask_b_reg;
    logic              out_valid_reg, out_valid_next;
    pick_t             out_pick_reg;
    pick_t             pick;
    logic              load_out;
    logic              load_in;

    assign load_out = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || load_out;
    assign load_in  = s_valid && s_ready;

    tgrr_picker u_picker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .mask_a  (mask_a_reg),
        .mask_b  (mask_b_reg),
        .update  (load_out),
        .pick    (pick)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (load_in) begin
            in_valid_next = 1'b1;
        end else if (load_out) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (load_in) begin
            mask_a_reg <= s_requests_group_a;
            mask_b_reg <= s_requests_group_b;
        end
        if (load_out) begin
            out_pick_reg <= pick;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_granted     = out_pick_reg.granted;
    assign m_grant_group = out_pick_reg.group;
    assign m_grant_slot  = GRANT_SLOT_W'(out_pick_reg.slot);

`ifndef SYNTH
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_granted |-> !m_grant_group && (m_grant_slot == '0))
        else $error("idle word carries a nonzero group or slot");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("input stalled with empty result register");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_valid)
        else $error("moved word not presented on result channel");
`endif

endmodule
